// File: design/bfl_pkg.sv
// Shared types and constants for the exact-then-best-fit free list unit.
package bfl_pkg;

    // Capacity of the slot table and derived widths
    localparam int MAX_BLOCKS = 64;
    localparam int SLOT_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int VAL_W      = 31;
    localparam int ENTRY_W    = 2 * VAL_W;

    // Command codes of an input beat
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_DUMP    = 2'd2
    } cmd_t;

    // Status codes of a result beat
    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_EXACT      = 3'd2,
        ST_SPLIT      = 3'd3,
        ST_NO_FIT     = 3'd4,
        ST_DUMP_ENTRY = 3'd5,
        ST_DUMP_EMPTY = 3'd6
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [VAL_W-1:0] start_address;
        logic [VAL_W-1:0] block_length;
        logic [VAL_W-1:0] request_size;
    } in_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] block_address;
        logic [VAL_W-1:0] remaining_length;
        logic             last;
    } out_t;

endpackage

// File: design/bfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/exact_then_best_fit_free_list_unit.sv
// Load: the result is registered and appears in the next cycle. Request: one pass of slot
// reads round the ring through the one RAM read port, followed by a successor search after
// an exact removal. Dump: one pass of slot reads, one result per live block as its slot
// word arrives. One item at a time; busy is high while working.
// Results are single-cycle strobes; the receiver cannot stall them.
// Reset (rst_n low, async) empties the list; the slot RAM itself is not cleared.
module exact_then_best_fit_free_list_unit
    import bfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic result_valid,
    output out_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SUCC,
        S_DUMP
    } state_t;

    // Step a slot index round the ring
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(MAX_BLOCKS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    state_t                state_reg, state_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]      slots_used_reg, slots_used_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic [SLOT_W-1:0]     scan_start_reg, scan_start_next;
    logic [VAL_W-1:0]      req_reg, req_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  pend_live_reg, pend_live_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic                  exact_found_reg, exact_found_next;
    logic [SLOT_W-1:0]     exact_slot_reg, exact_slot_next;
    logic [VAL_W-1:0]      exact_addr_reg, exact_addr_next;
    logic                  best_found_reg, best_found_next;
    logic [SLOT_W-1:0]     best_slot_reg, best_slot_next;
    logic [VAL_W-1:0]      best_addr_reg, best_addr_next;
    logic [VAL_W-1:0]      best_len_reg, best_len_next;
    logic [SLOT_W-1:0]     succ_slot_reg, succ_slot_next;
    logic [CNT_W-1:0]      succ_cnt_reg, succ_cnt_next;
    logic [CNT_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic                  result_valid_reg, result_valid_next;
    out_t                  result_reg, result_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]      rd_addr;
    logic [VAL_W-1:0]      rd_len;
    logic                  issue_done;
    logic [SLOT_W-1:0]     load_slot;

    // Slot table: address in the upper half, length in the lower half
    bfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    assign rd_addr    = ram_rdata[ENTRY_W-1:VAL_W];
    assign rd_len     = ram_rdata[VAL_W-1:0];
    assign issue_done = (issue_cnt_reg == CNT_W'(MAX_BLOCKS));
    assign load_slot  = slots_used_reg[SLOT_W-1:0];

    // Next-state logic for command decode, ring scan, successor search and dump
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        slots_used_next   = slots_used_reg;
        live_next         = live_reg;
        scan_start_next   = scan_start_reg;
        req_next          = req_reg;
        rd_slot_next      = rd_slot_reg;
        issue_cnt_next    = issue_cnt_reg;
        pend_next         = 1'b0;
        pend_live_next    = pend_live_reg;
        pend_slot_next    = pend_slot_reg;
        exact_found_next  = exact_found_reg;
        exact_slot_next   = exact_slot_reg;
        exact_addr_next   = exact_addr_reg;
        best_found_next   = best_found_reg;
        best_slot_next    = best_slot_reg;
        best_addr_next    = best_addr_reg;
        best_len_next     = best_len_reg;
        succ_slot_next    = succ_slot_reg;
        succ_cnt_next     = succ_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = load_slot;
        ram_wdata         = {item.start_address, item.block_length};
        ram_re            = 1'b0;

        // Issue one slot read per cycle while the ring pass is open
        if ((state_reg == S_SCAN || state_reg == S_DUMP) && !issue_done)
        begin
            ram_re         = 1'b1;
            pend_next      = 1'b1;
            pend_slot_next = rd_slot_reg;
            pend_live_next = valid_reg[rd_slot_reg];
            rd_slot_next   = slot_inc(rd_slot_reg);
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.cmd)
                        CMD_LOAD:
                        begin
                            result_valid_next = 1'b1;
                            result_next.block_address    = item.start_address;
                            result_next.remaining_length = item.block_length;
                            result_next.last             = 1'b1;
                            if (slots_used_reg >= CNT_W'(MAX_BLOCKS))
                            begin
                                result_next.status = ST_TABLE_FULL;
                            end
                            else
                            begin
                                result_next.status    = ST_LOADED;
                                ram_we                = 1'b1;
                                valid_next[load_slot] = 1'b1;
                                if (live_reg == '0)
                                begin
                                    scan_start_next = load_slot;
                                end
                                slots_used_next = slots_used_reg + CNT_W'(1);
                                live_next       = live_reg + CNT_W'(1);
                            end
                        end
                        CMD_REQUEST:
                        begin
                            req_next         = item.request_size;
                            rd_slot_next     = scan_start_reg;
                            issue_cnt_next   = '0;
                            exact_found_next = 1'b0;
                            best_found_next  = 1'b0;
                            state_next       = S_SCAN;
                        end
                        CMD_DUMP:
                        begin
                            if (live_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                                result_next.status           = ST_DUMP_EMPTY;
                                result_next.block_address    = '0;
                                result_next.remaining_length = '0;
                                result_next.last             = 1'b1;
                            end
                            else
                            begin
                                rd_slot_next   = scan_start_reg;
                                issue_cnt_next = '0;
                                emit_cnt_next  = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Track first exact match and smallest strictly longer block
                if (pend_reg && pend_live_reg)
                begin
                    if (!exact_found_reg && rd_len == req_reg)
                    begin
                        exact_found_next = 1'b1;
                        exact_slot_next  = pend_slot_reg;
                        exact_addr_next  = rd_addr;
                    end
                    if (rd_len > req_reg && (!best_found_reg || rd_len < best_len_reg))
                    begin
                        best_found_next = 1'b1;
                        best_slot_next  = pend_slot_reg;
                        best_addr_next  = rd_addr;
                        best_len_next   = rd_len;
                    end
                end
                // Pass complete: apply the outcome
                if (issue_done && !pend_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next.last  = 1'b1;
                    if (exact_found_reg)
                    begin
                        result_next.status           = ST_EXACT;
                        result_next.block_address    = exact_addr_reg;
                        result_next.remaining_length = '0;
                        valid_next[exact_slot_reg]   = 1'b0;
                        live_next                    = live_reg - CNT_W'(1);
                        succ_slot_next               = slot_inc(exact_slot_reg);
                        succ_cnt_next                = CNT_W'(1);
                        state_next                   = S_SUCC;
                    end
                    else if (best_found_reg)
                    begin
                        result_next.status           = ST_SPLIT;
                        result_next.block_address    = best_addr_reg;
                        result_next.remaining_length = best_len_reg - req_reg;
                        ram_we                       = 1'b1;
                        ram_waddr                    = best_slot_reg;
                        ram_wdata                    = {best_addr_reg, best_len_reg - req_reg};
                        scan_start_next              = best_slot_reg;
                        state_next                   = S_IDLE;
                    end
                    else
                    begin
                        result_next.status           = ST_NO_FIT;
                        result_next.block_address    = '0;
                        result_next.remaining_length = '0;
                        state_next                   = S_IDLE;
                    end
                end
            end

            S_SUCC:
            begin
                // Walk forward to the next live slot after the removed one
                if (valid_reg[succ_slot_reg])
                begin
                    scan_start_next = succ_slot_reg;
                    state_next      = S_IDLE;
                end
                else if (succ_cnt_reg >= CNT_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    succ_slot_next = slot_inc(succ_slot_reg);
                    succ_cnt_next  = succ_cnt_reg + CNT_W'(1);
                end
            end

            S_DUMP:
            begin
                // Emit one beat per live slot in ring order
                if (pend_reg && pend_live_reg)
                begin
                    result_valid_next            = 1'b1;
                    result_next.status           = ST_DUMP_ENTRY;
                    result_next.block_address    = rd_addr;
                    result_next.remaining_length = rd_len;
                    result_next.last             = ((emit_cnt_reg + CNT_W'(1)) == live_reg);
                    emit_cnt_next                = emit_cnt_reg + CNT_W'(1);
                end
                if (issue_done && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            slots_used_reg   <= '0;
            live_reg         <= '0;
            scan_start_reg   <= '0;
            req_reg          <= '0;
            rd_slot_reg      <= '0;
            issue_cnt_reg    <= '0;
            pend_reg         <= 1'b0;
            pend_live_reg    <= 1'b0;
            pend_slot_reg    <= '0;
            exact_found_reg  <= 1'b0;
            exact_slot_reg   <= '0;
            exact_addr_reg   <= '0;
            best_found_reg   <= 1'b0;
            best_slot_reg    <= '0;
            best_addr_reg    <= '0;
            best_len_reg     <= '0;
            succ_slot_reg    <= '0;
            succ_cnt_reg     <= '0;
            emit_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            slots_used_reg   <= slots_used_next;
            live_reg         <= live_next;
            scan_start_reg   <= scan_start_next;
            req_reg          <= req_next;
            rd_slot_reg      <= rd_slot_next;
            issue_cnt_reg    <= issue_cnt_next;
            pend_reg         <= pend_next;
            pend_live_reg    <= pend_live_next;
            pend_slot_reg    <= pend_slot_next;
            exact_found_reg  <= exact_found_next;
            exact_slot_reg   <= exact_slot_next;
            exact_addr_reg   <= exact_addr_next;
            best_found_reg   <= best_found_next;
            best_slot_reg    <= best_slot_next;
            best_addr_reg    <= best_addr_next;
            best_len_reg     <= best_len_next;
            succ_slot_reg    <= succ_slot_next;
            succ_cnt_reg     <= succ_cnt_next;
            emit_cnt_reg     <= emit_cnt_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
